### rtl/core/wdso_pkg.sv
// ----------------------------------------------------------------------------
// wdso_pkg
// Shared types and constants for the water dipole slice profiler.
// ----------------------------------------------------------------------------
package wdso_pkg;

  localparam int POS_W     = 26;  // wrapped position, Q16 nm
  localparam int ACC_W     = 44;  // charge-weighted position sum, Q30
  localparam int DIP_W     = 32;  // dipole component, Q16
  localparam int COS_W     = 18;  // per-molecule cosine, holds +-32768
  localparam int CNT_W     = 24;
  localparam int CSUM_W    = 40;
  localparam int DSUM_W    = 48;
  localparam int DNUM_W    = 48;  // divider numerator and quotient
  localparam int DDEN_W    = 32;  // divider divisor
  localparam int NSL_W     = 7;   // slices in use, up to 64
  localparam int SLICES_PER_NM = 10;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  localparam logic [2:0] CFG_BOX_X    = 3'd0;
  localparam logic [2:0] CFG_BOX_Y    = 3'd1;
  localparam logic [2:0] CFG_BOX_Z    = 3'd2;
  localparam logic [2:0] CFG_CHARGE_O = 3'd3;
  localparam logic [2:0] CFG_CHARGE_H = 3'd4;
  localparam logic [2:0] CFG_SLICES   = 3'd5;
  localparam logic [2:0] CFG_AXIS     = 3'd6;

  localparam logic [1:0] ACT_ACC   = 2'd0;
  localparam logic [1:0] ACT_EMIT  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_SQ,
    S_SQRT,
    S_CST,
    S_COS,
    S_SLMUL,
    S_SLDIV,
    S_RD,
    S_UPD,
    S_ERD,
    S_ECHK,
    S_EDIV,
    S_OUT
  } state_e;

  typedef struct packed {
    logic        [CNT_W-1:0]  cnt;
    logic signed [CSUM_W-1:0] cos;
    logic signed [DSUM_W-1:0] dx;
    logic signed [DSUM_W-1:0] dy;
    logic signed [DSUM_W-1:0] dz;
  } slice_entry_t;

endpackage

### rtl/core/water_dipole_slice_order.sv
// ----------------------------------------------------------------------------
// water_dipole_slice_order
// Bins water molecules into slices along one box axis and keeps per-slice
// sums of orientation cosine and dipole, with emit and clear actions.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 word
//  --------  ---------  ------------------------  -------------------------------
//  cfg       in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//  in        in         in_valid_i / in_ready_o   action_i, nine atom coordinates
//  out       out        out_valid_o / out_ready_i slice result, last_of_run_o
//
//  One word is taken at a time; in_ready_o is high only while the sequencer
//  idles. An accumulate word forms the charge-weighted sums and squares on the shared
//  32x32 multiplier, 32 steps of the square root, and two 48-step passes of the
//  shared restoring divider (cosine, slice), then a read-modify-write of the
//  slice store. An emit word runs four 48-step divider passes for each slice
//  that holds molecules; a clear word goes straight to output, action 3 back to idle.
//  Reset clears the slice store at once through per-slice valid bits, so no
//  clearing pass is needed. A stalled output holds its word in the output
//  register; the sequencer waits before loading the next result.
//
module water_dipole_slice_order #(
  parameter int MAX_SLICES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [22:0] cfg_data_i,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic signed [23:0] oxygen_x_i,
  input  logic signed [23:0] oxygen_y_i,
  input  logic signed [23:0] oxygen_z_i,
  input  logic signed [23:0] hydrogen1_x_i,
  input  logic signed [23:0] hydrogen1_y_i,
  input  logic signed [23:0] hydrogen1_z_i,
  input  logic signed [23:0] hydrogen2_x_i,
  input  logic signed [23:0] hydrogen2_y_i,
  input  logic signed [23:0] hydrogen2_z_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  slice_index_o,
  output logic        in_range_o,
  output logic signed [15:0] mean_cosine_o,
  output logic signed [31:0] mean_dipole_x_o,
  output logic signed [31:0] mean_dipole_y_o,
  output logic signed [31:0] mean_dipole_z_o,
  output logic [23:0] molecule_count_o,
  output logic        last_of_run_o
);

  import wdso_pkg::*;

  localparam int IW = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
  localparam logic [NSL_W-1:0] NMAX = NSL_W'(MAX_SLICES);

  // Configuration registers
  logic        [22:0] box_q [3];
  logic signed [15:0] qo_q, qh_q;
  logic        [6:0]  nsl_q;
  logic        [1:0]  axis_sel_q;

  state_e state_q, state_d;

  // Per-molecule working registers
  logic [1:0]               act_q;
  logic signed [POS_W-1:0]  pos_q [3][3];
  logic [1:0]               at_q, ax_q, sub_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [DIP_W-1:0]  dip_q [3];
  logic [63:0]              sq_q, sv_q, sr_q, sb_q;
  logic signed [COS_W-1:0]  cos_q;
  logic [1:0]               axis_q;
  logic [NSL_W-1:0]         n_q, i_q;
  logic [22:0]              boxa_q;
  logic                     inr_q;
  logic [IW-1:0]            slice_q;
  logic [CNT_W-1:0]         mcount_q;
  logic signed [15:0]       ecos_q;
  logic signed [31:0]       edx_q, edy_q, edz_q;

  // Shared divider
  logic [DNUM_W-1:0] dn_q;
  logic [DDEN_W:0]   dr_q;
  logic [DDEN_W-1:0] dd_q;
  logic [5:0]        dc_q;
  logic              dneg_q;

  // Slice store
  slice_entry_t          mem [MAX_SLICES];
  logic [MAX_SLICES-1:0] valid_q;
  slice_entry_t          ent_q, ent_e, ent_new;
  logic                  ent_v_q;

  logic out_valid_q;

  // --------------------------------------------------------------------------
  // Axis and slice count in use
  // --------------------------------------------------------------------------
  logic [1:0]  axis_w;
  logic [22:0] boxa_w;
  logic [26:0] box10;
  logic [10:0] nauto, nsel;
  logic [NSL_W-1:0] n_w;

  always_comb begin
    axis_w = (axis_sel_q == AXIS_X || axis_sel_q == AXIS_Y) ? axis_sel_q : 2'd2;
    boxa_w = box_q[axis_w];
    box10  = {4'd0, boxa_w} * 27'(SLICES_PER_NM);
    nauto  = box10[26:16];
    nsel   = (nsl_q != '0) ? {4'd0, nsl_q} : nauto;
    n_w    = (nsel > {4'd0, NMAX}) ? NMAX : nsel[NSL_W-1:0];
  end

  // --------------------------------------------------------------------------
  // Wrap into the box on the oxygen, per axis
  // --------------------------------------------------------------------------
  logic signed [23:0]      in_pos [3][3];
  logic signed [POS_W-1:0] pos_w  [3][3];
  logic signed [POS_W-1:0] shift_w, boxs;

  always_comb begin
    in_pos[0][0] = oxygen_x_i;    in_pos[0][1] = oxygen_y_i;    in_pos[0][2] = oxygen_z_i;
    in_pos[1][0] = hydrogen1_x_i; in_pos[1][1] = hydrogen1_y_i; in_pos[1][2] = hydrogen1_z_i;
    in_pos[2][0] = hydrogen2_x_i; in_pos[2][1] = hydrogen2_y_i; in_pos[2][2] = hydrogen2_z_i;
    shift_w = '0;
    boxs    = '0;
    for (int j = 0; j < 3; j++) begin
      boxs = $signed({3'd0, box_q[j]});
      if (in_pos[0][j] < 0) begin
        shift_w = boxs;
      end else if (POS_W'(in_pos[0][j]) > boxs) begin
        shift_w = -boxs;
      end else begin
        shift_w = '0;
      end
      for (int a = 0; a < 3; a++) begin
        pos_w[a][j] = POS_W'(in_pos[a][j]) + shift_w;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Shared multiplier
  // --------------------------------------------------------------------------
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MUL: begin
        mul_a = 32'(pos_q[at_q][ax_q]);
        mul_b = (at_q == 2'd0) ? 32'(qo_q) : 32'(qh_q);
      end
      S_SQ: begin
        mul_a = dip_q[ax_q];
        mul_b = dip_q[ax_q];
      end
      S_SLMUL: begin
        mul_a = 32'(pos_q[0][axis_q]);
        mul_b = $signed({25'd0, n_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  logic signed [ACC_W-1:0] acc_sum, dip_rnd;
  assign acc_sum = acc_q + $signed(mul_p[ACC_W-1:0]);
  assign dip_rnd = (acc_sum + ACC_W'(8192)) >>> 14;

  // Square root step
  logic [63:0] sq_t;
  logic        sq_ge;
  assign sq_t  = sr_q + sb_q;
  assign sq_ge = (sv_q >= sq_t);

  // Divider step
  logic [DDEN_W:0]         dv_rsh;
  logic                    dv_ge;
  logic [DNUM_W-1:0]       dv_q;
  logic signed [DNUM_W:0]  dv_sq;
  logic                    dv_done;
  assign dv_rsh  = {dr_q[DDEN_W-1:0], dn_q[DNUM_W-1]};
  assign dv_ge   = (dv_rsh >= {1'b0, dd_q});
  assign dv_q    = {dn_q[DNUM_W-2:0], dv_ge};
  assign dv_sq   = dneg_q ? -$signed({1'b0, dv_q}) : $signed({1'b0, dv_q});
  assign dv_done = (dc_q == '0);

  logic sl_inr;
  assign sl_inr = dneg_q ? (dv_q == '0) : (dv_q < DNUM_W'(n_q));

  // Slice-position product magnitude
  logic signed [DNUM_W:0] slp;
  logic [DNUM_W-1:0]      slmag;
  assign slp   = (DNUM_W+1)'(mul_p);
  assign slmag = slp[DNUM_W] ? DNUM_W'(-slp) : slp[DNUM_W-1:0];

  // Cosine numerator magnitude
  logic signed [DIP_W-1:0] dipa;
  logic [DNUM_W-1:0]       cmag;
  assign dipa = dip_q[axis_q];
  assign cmag = DNUM_W'(dipa[DIP_W-1] ? -dipa : dipa) << 15;

  // Emit: pick the sum to divide next
  logic [1:0]             esel;
  logic signed [DNUM_W:0] esum;
  logic [DNUM_W-1:0]      emag;

  assign ent_e = ent_v_q ? ent_q : '0;

  always_comb begin
    esel = (state_q == S_ECHK) ? 2'd0 : 2'(sub_q + 2'd1);
    case (esel)
      2'd0:    esum = (DNUM_W+1)'(ent_e.cos);
      2'd1:    esum = (DNUM_W+1)'(ent_e.dx);
      2'd2:    esum = (DNUM_W+1)'(ent_e.dy);
      default: esum = (DNUM_W+1)'(ent_e.dz);
    endcase
    emag = esum[DNUM_W] ? DNUM_W'(-esum) : esum[DNUM_W-1:0];
  end

  // Slice update with saturating dipole sums
  function automatic logic signed [DSUM_W-1:0] sat_add(logic signed [DSUM_W-1:0] s,
                                                       logic signed [DIP_W-1:0] d);
    logic signed [DSUM_W:0] t;
    t = (DSUM_W+1)'(s) + (DSUM_W+1)'(d);
    if (t[DSUM_W] != t[DSUM_W-1]) begin
      sat_add = t[DSUM_W] ? {1'b1, {(DSUM_W-1){1'b0}}} : {1'b0, {(DSUM_W-1){1'b1}}};
    end else begin
      sat_add = t[DSUM_W-1:0];
    end
  endfunction

  logic ent_full;
  assign ent_full = (ent_e.cnt == COUNT_MAX);

  always_comb begin
    ent_new.cnt = ent_e.cnt + CNT_W'(1);
    ent_new.cos = ent_e.cos + CSUM_W'(cos_q);
    ent_new.dx  = sat_add(ent_e.dx, dip_q[0]);
    ent_new.dy  = sat_add(ent_e.dy, dip_q[1]);
    ent_new.dz  = sat_add(ent_e.dz, dip_q[2]);
  end

  logic          mem_re, mem_we;
  logic [IW-1:0] rd_addr;
  assign mem_re  = (state_q == S_RD) || (state_q == S_ERD);
  assign rd_addr = (state_q == S_RD) ? slice_q : i_q[IW-1:0];
  assign mem_we  = (state_q == S_UPD) && !ent_full;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic in_fire, out_free, emit_more;
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign emit_more   = (act_q == ACT_EMIT) && ((i_q + NSL_W'(1)) < n_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (action_i)
            ACT_ACC:   state_d = S_MUL;
            ACT_EMIT:  state_d = (n_w == '0) ? S_IDLE : S_ERD;
            ACT_CLEAR: state_d = S_OUT;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_MUL:   if (at_q == 2'd2 && ax_q == 2'd2) state_d = S_SQ;
      S_SQ:    if (ax_q == 2'd2) state_d = S_SQRT;
      S_SQRT:  if (sb_q[0]) state_d = S_CST;
      S_CST:   state_d = (sr_q == '0) ? S_SLMUL : S_COS;
      S_COS:   if (dv_done) state_d = S_SLMUL;
      S_SLMUL: state_d = (boxa_q == '0 || n_q == '0) ? S_OUT : S_SLDIV;
      S_SLDIV: if (dv_done) state_d = sl_inr ? S_RD : S_OUT;
      S_RD:    state_d = S_UPD;
      S_UPD:   state_d = S_OUT;
      S_ERD:   state_d = S_ECHK;
      S_ECHK:  state_d = (ent_e.cnt == '0) ? S_OUT : S_EDIV;
      S_EDIV:  if (dv_done && sub_q == 2'd3) state_d = S_OUT;
      S_OUT:   if (out_free) state_d = emit_more ? S_ERD : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control state, configuration and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      box_q[0]    <= 23'd655360;
      box_q[1]    <= 23'd655360;
      box_q[2]    <= 23'd655360;
      qo_q        <= -16'sd13664;
      qh_q        <= 16'sd6832;
      nsl_q       <= '0;
      axis_sel_q  <= 2'd2;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_BOX_X:    box_q[0]   <= cfg_data_i;
          CFG_BOX_Y:    box_q[1]   <= cfg_data_i;
          CFG_BOX_Z:    box_q[2]   <= cfg_data_i;
          CFG_CHARGE_O: qo_q       <= $signed(cfg_data_i[15:0]);
          CFG_CHARGE_H: qh_q       <= $signed(cfg_data_i[15:0]);
          CFG_SLICES:   nsl_q      <= cfg_data_i[6:0];
          CFG_AXIS:     axis_sel_q <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      // drop the whole store at once on clear
      if (in_fire && action_i == ACT_CLEAR) valid_q <= '0;
      if (mem_we) valid_q[slice_q] <= 1'b1;
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Slice store
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[slice_q] <= ent_new;
    if (mem_re) begin
      ent_q   <= mem[rd_addr];
      ent_v_q <= valid_q[rd_addr];
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          act_q  <= action_i;
          pos_q  <= pos_w;
          acc_q  <= '0;
          sq_q   <= '0;
          at_q   <= '0;
          ax_q   <= '0;
          i_q    <= '0;
          n_q    <= n_w;
          axis_q <= axis_w;
          boxa_q <= boxa_w;
          inr_q  <= 1'b0;
        end
      end
      S_MUL: begin
        if (at_q == 2'd2) begin
          dip_q[ax_q] <= dip_rnd[DIP_W-1:0];
          acc_q       <= '0;
          at_q        <= '0;
          ax_q        <= (ax_q == 2'd2) ? 2'd0 : 2'(ax_q + 2'd1);
        end else begin
          acc_q <= acc_sum;
          at_q  <= 2'(at_q + 2'd1);
        end
      end
      S_SQ: begin
        sq_q <= sq_q + 64'(mul_p);
        ax_q <= 2'(ax_q + 2'd1);
        if (ax_q == 2'd2) begin
          sv_q <= sq_q + 64'(mul_p);
          sr_q <= '0;
          sb_q <= 64'd1 << 62;
        end
      end
      S_SQRT: begin
        if (sq_ge) begin
          sv_q <= sv_q - sq_t;
          sr_q <= (sr_q >> 1) + sb_q;
        end else begin
          sr_q <= sr_q >> 1;
        end
        sb_q <= sb_q >> 2;
      end
      S_CST: begin
        if (sr_q == '0) begin
          cos_q <= '0;
        end else begin
          dn_q   <= cmag;
          dr_q   <= '0;
          dd_q   <= sr_q[DDEN_W-1:0];
          dc_q   <= 6'(DNUM_W - 1);
          dneg_q <= dipa[DIP_W-1];
        end
      end
      S_COS, S_SLDIV, S_EDIV: begin
        dn_q <= dv_q;
        dr_q <= dv_ge ? (dv_rsh - {1'b0, dd_q}) : dv_rsh;
        dc_q <= 6'(dc_q - 6'd1);
        if (dv_done) begin
          if (state_q == S_COS) begin
            cos_q <= dv_sq[COS_W-1:0];
          end else if (state_q == S_SLDIV) begin
            inr_q   <= sl_inr;
            slice_q <= dv_q[IW-1:0];
          end else begin
            case (sub_q)
              2'd0: begin
                if (dv_sq > 32767) begin
                  ecos_q <= 16'sd32767;
                end else if (dv_sq < -32768) begin
                  ecos_q <= -16'sd32768;
                end else begin
                  ecos_q <= dv_sq[15:0];
                end
              end
              2'd1:    edx_q <= dv_sq[31:0];
              2'd2:    edy_q <= dv_sq[31:0];
              default: edz_q <= dv_sq[31:0];
            endcase
            // advance to the next sum of this slice
            if (sub_q != 2'd3) begin
              sub_q  <= 2'(sub_q + 2'd1);
              dn_q   <= emag;
              dr_q   <= '0;
              dd_q   <= DDEN_W'(ent_e.cnt);
              dc_q   <= 6'(DNUM_W - 1);
              dneg_q <= esum[DNUM_W];
            end
          end
        end
      end
      S_SLMUL: begin
        dn_q   <= slmag;
        dr_q   <= '0;
        dd_q   <= DDEN_W'(boxa_q);
        dc_q   <= 6'(DNUM_W - 1);
        dneg_q <= slp[DNUM_W];
      end
      S_UPD: begin
        mcount_q <= ent_full ? ent_e.cnt : ent_new.cnt;
      end
      S_ECHK: begin
        sub_q  <= '0;
        ecos_q <= '0;
        edx_q  <= '0;
        edy_q  <= '0;
        edz_q  <= '0;
        dn_q   <= emag;
        dr_q   <= '0;
        dd_q   <= DDEN_W'(ent_e.cnt);
        dc_q   <= 6'(DNUM_W - 1);
        dneg_q <= esum[DNUM_W];
      end
      S_OUT: begin
        if (out_free && emit_more) i_q <= NSL_W'(i_q + NSL_W'(1));
      end
      default: ;
    endcase
  end

  // Output register: hold until taken
  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      case (act_q)
        ACT_ACC: begin
          slice_index_o    <= inr_q ? 6'(slice_q) : 6'd0;
          in_range_o       <= inr_q;
          mean_cosine_o    <= (cos_q > 32767) ? 16'sd32767 : cos_q[15:0];
          mean_dipole_x_o  <= dip_q[0];
          mean_dipole_y_o  <= dip_q[1];
          mean_dipole_z_o  <= dip_q[2];
          molecule_count_o <= inr_q ? mcount_q : '0;
          last_of_run_o    <= 1'b1;
        end
        ACT_EMIT: begin
          slice_index_o    <= i_q[5:0];
          in_range_o       <= (ent_e.cnt != '0);
          mean_cosine_o    <= ecos_q;
          mean_dipole_x_o  <= edx_q;
          mean_dipole_y_o  <= edy_q;
          mean_dipole_z_o  <= edz_q;
          molecule_count_o <= ent_e.cnt;
          last_of_run_o    <= !emit_more;
        end
        default: begin
          slice_index_o    <= '0;
          in_range_o       <= 1'b0;
          mean_cosine_o    <= '0;
          mean_dipole_x_o  <= '0;
          mean_dipole_y_o  <= '0;
          mean_dipole_z_o  <= '0;
          molecule_count_o <= '0;
          last_of_run_o    <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
